/* rtl/core/ntt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_pkg: shared types and constants
// Transaction structs, modulus, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package ntt_pkg;

    localparam int          LOG_MAX_DEF = 10;
    localparam logic [29:0] MODULUS     = 30'd998244353;
    localparam logic [29:0] GEN         = 30'd3;
    localparam int          ODD_PART    = 119;
    localparam int          TWO_EXP     = 23;

    // Operation codes
    localparam logic [1:0] KIND_WRITE     = 2'd0;
    localparam logic [1:0] KIND_TRANSFORM = 2'd1;
    localparam logic [1:0] KIND_READ      = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] REG_LOG_SIZE = 1'b0;
    localparam logic [0:0] REG_INVERSE  = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  index;
        logic [29:0] value;
    } ntt_in_t;

    typedef struct packed {
        logic [29:0] read_value;
        logic        read_valid;
    } ntt_out_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WRITE,      // reduce and store a coefficient
        ST_READ_WAIT,  // RAM read latency
        ST_READ_OUT,
        ST_ROOT_INIT,  // set up root exponentiation
        ST_POW_MUL,    // one modmul step of an exponentiation
        ST_POW_WAIT,
        ST_INV_ROOT,   // decide next exponentiation phase
        ST_REV_RD_A,   // bit-reversal: read i
        ST_REV_RD_B,   // read r
        ST_REV_WR_A,
        ST_REV_WR_B,
        ST_REV_NEXT,
        ST_STAGE_INIT, // compute stage step root
        ST_BF_RD_LO,
        ST_BF_RD_HI,
        ST_BF_MUL_GO,  // issue t = w * hi
        ST_BF_MUL,     // wait for t
        ST_BF_WR_HI,
        ST_BF_WR_LO,
        ST_BF_W,       // w = w * step
        ST_BF_NEXT,
        ST_SC_RD,
        ST_SC_MUL_GO,  // issue scale product
        ST_SC_MUL,
        ST_SC_WR,
        ST_DONE
    } ntt_state_t;

    // Handshake between sequencer and modular multiplier
    typedef struct packed {
        logic        start;
        logic [29:0] a;
        logic [29:0] b;
    } ntt_mul_req_t;

    typedef struct packed {
        logic        done;
        logic [29:0] product;
    } ntt_mul_rsp_t;

endpackage

/* rtl/core/ntt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ntt_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/core/ntt_modmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_modmul: iterative modular multiplier
// Computes a*b mod p by shift-add, two bits of b per cycle.
// ----------------------------------------------------------------------------
module ntt_modmul
    import ntt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ntt_mul_req_t req,
    output ntt_mul_rsp_t rsp
);

    logic [29:0] a_reg, a_next;
    logic [29:0] b_reg, b_next;
    logic [29:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // double-and-add of one bit, inputs below p
    function automatic logic [29:0] step_bit(input logic [29:0] acc, input logic [29:0] a,
                                              input logic bit_in);
        logic [30:0] d;
        logic [30:0] s;
        begin
            d = {acc, 1'b0};
            if (d >= {1'b0, MODULUS})
            begin
                d = d - {1'b0, MODULUS};
            end
            s = d + (bit_in ? {1'b0, a} : 31'd0);
            if (s >= {1'b0, MODULUS})
            begin
                s = s - {1'b0, MODULUS};
            end
            step_bit = s[29:0];
        end
    endfunction

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = step_bit(step_bit(acc_reg, a_reg, b_reg[29]), a_reg, b_reg[28]);
            b_next   = {b_reg[27:0], 2'b00};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd14)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

/* rtl/core/ntt_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_seq: transform sequencer
// Walks write, read, bit-reversal, butterfly and scaling steps over the
// coefficient RAM, issuing every product to the shared modular multiplier.
// ----------------------------------------------------------------------------
module ntt_seq
    import ntt_pkg::*;
#(
    parameter int LOG_MAX = LOG_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ntt_in_t            cmd,
    input  logic [3:0]         log_size,
    input  logic               inverse_mode,
    output logic               busy,
    output logic               result_strobe,
    output ntt_out_t           result,
    output ntt_mul_req_t       mul_req,
    input  ntt_mul_rsp_t       mul_rsp,
    output logic               ram_we,
    output logic [LOG_MAX-1:0] ram_addr,
    output logic [29:0]        ram_wdata,
    input  logic [29:0]        ram_rdata
);

    localparam int CW = LOG_MAX + 1;
    localparam int LW = $clog2(LOG_MAX + 1);

    // exponentiation phases
    typedef enum logic [1:0] {
        PH_ROOT,
        PH_INV_ROOT,
        PH_STEP,
        PH_SCALE
    } phase_t;

    ntt_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;

    ntt_in_t     cmd_reg, cmd_next;
    logic [LW-1:0] lg_reg, lg_next;
    logic        inv_reg, inv_next;
    logic [CW-1:0] i_reg, i_next;       // generic index
    logic [CW-1:0] j_reg, j_next;       // block base
    logic [LW-1:0] s_reg, s_next;       // stage number 1..lg
    logic [29:0] root_reg, root_next;
    logic [29:0] step_reg, step_next;
    logic [29:0] w_reg, w_next;
    logic [29:0] lo_reg, lo_next;
    logic [29:0] hi_reg, hi_next;       // also swap temp / t
    logic [29:0] scale_reg, scale_next;
    // exponentiation: base, acc, remaining exponent
    logic [29:0] pb_reg, pb_next;
    logic [29:0] pa_reg, pa_next;
    logic [31:0] pe_reg, pe_next;
    logic        psq_reg, psq_next;     // next product is base squaring
    logic        out_v_reg, out_v_next;
    logic [29:0] out_d_reg, out_d_next;
    logic        rd_valid_reg;

    logic [CW-1:0] n_len;
    logic [CW-1:0] half;
    logic [CW-1:0] rev_i;
    logic [29:0]   sum_lo, sum_hi;
    logic [30:0]   tmp_s;
    logic [LW-1:0] lg_eff;
    logic [29:0]   val_red;

    assign n_len = CW'(1) << lg_reg;
    assign half  = CW'(1) << (s_reg - LW'(1));

    // effective length code from the register
    always_comb
    begin
        if (log_size == 4'd0)
        begin
            lg_eff = LW'(1);
        end
        else if (32'(log_size) > LOG_MAX)
        begin
            lg_eff = LW'(LOG_MAX);
        end
        else
        begin
            lg_eff = LW'(log_size);
        end
    end

    // bit reversal of i over lg bits
    always_comb
    begin
        rev_i = '0;
        for (int k = 0; k < LOG_MAX; k++)
        begin
            if (k < int'(lg_reg))
            begin
                rev_i[int'(lg_reg) - 1 - k] = i_reg[k];
            end
        end
    end

    // butterfly add and subtract, hi_reg holds t
    always_comb
    begin
        tmp_s = {1'b0, lo_reg} + {1'b0, hi_reg};
        if (tmp_s >= {1'b0, MODULUS})
        begin
            tmp_s = tmp_s - {1'b0, MODULUS};
        end
        sum_lo = tmp_s[29:0];
        if (lo_reg >= hi_reg)
        begin
            sum_hi = lo_reg - hi_reg;
        end
        else
        begin
            sum_hi = lo_reg + (MODULUS - hi_reg);
        end
    end

    // one conditional subtract reduces a 30-bit value
    assign val_red = (cmd_reg.value >= MODULUS) ? cmd_reg.value - MODULUS : cmd_reg.value;

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        lg_next    = lg_reg;
        inv_next   = inv_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        s_next     = s_reg;
        root_next  = root_reg;
        step_next  = step_reg;
        w_next     = w_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        scale_next = scale_reg;
        pb_next    = pb_reg;
        pa_next    = pa_reg;
        pe_next    = pe_reg;
        psq_next   = psq_reg;
        out_v_next = 1'b0;
        out_d_next = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    lg_next  = lg_eff;
                    inv_next = inverse_mode;
                    unique case (cmd.kind)
                        KIND_WRITE:     state_next = ST_WRITE;
                        KIND_TRANSFORM: state_next = ST_ROOT_INIT;
                        KIND_READ:      state_next = ST_READ_WAIT;
                        default:        state_next = ST_DONE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                state_next = ST_DONE;
            end
            ST_READ_WAIT:
            begin
                state_next = ST_READ_OUT;
            end
            ST_READ_OUT:
            begin
                if (CW'(cmd_reg.index) < n_len)
                begin
                    out_v_next = 1'b1;
                    out_d_next = ram_rdata;
                end
                state_next = ST_IDLE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            ST_ROOT_INIT:
            begin
                phase_next = PH_ROOT;
                pb_next    = GEN;
                pa_next    = 30'd1;
                pe_next    = 32'(ODD_PART) << (TWO_EXP - int'(lg_reg));
                psq_next   = 1'b0;
                state_next = ST_POW_MUL;
            end
            ST_POW_MUL:
            begin
                if (pe_reg == '0)
                begin
                    state_next = ST_INV_ROOT;
                end
                else
                begin
                    state_next = ST_POW_WAIT;
                end
            end
            ST_POW_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (psq_reg)
                    begin
                        pb_next  = mul_rsp.product;
                        pe_next  = pe_reg >> 1;
                        psq_next = 1'b0;
                    end
                    else
                    begin
                        if (pe_reg[0])
                        begin
                            pa_next = mul_rsp.product;
                        end
                        psq_next = 1'b1;
                    end
                    state_next = ST_POW_MUL;
                end
            end
            ST_INV_ROOT:
            begin
                unique case (phase_reg)
                    PH_ROOT:
                    begin
                        root_next = pa_reg;
                        if (inv_reg)
                        begin
                            phase_next = PH_INV_ROOT;
                            pb_next    = pa_reg;
                            pa_next    = 30'd1;
                            pe_next    = 32'(n_len) - 32'd1;
                            state_next = ST_POW_MUL;
                        end
                        else
                        begin
                            i_next     = '0;
                            state_next = ST_REV_RD_A;
                        end
                    end
                    PH_INV_ROOT:
                    begin
                        root_next  = pa_reg;
                        i_next     = '0;
                        state_next = ST_REV_RD_A;
                    end
                    PH_STEP:
                    begin
                        step_next  = pa_reg;
                        w_next     = 30'd1;
                        j_next     = '0;
                        i_next     = '0;
                        state_next = ST_BF_RD_LO;
                    end
                    default:
                    begin
                        scale_next = pa_reg;
                        i_next     = '0;
                        state_next = ST_SC_RD;
                    end
                endcase
            end
            // bit-reversal permutation
            ST_REV_RD_A:
            begin
                if (i_reg < rev_i)
                begin
                    state_next = ST_REV_RD_B;
                end
                else
                begin
                    state_next = ST_REV_NEXT;
                end
            end
            ST_REV_RD_B:
            begin
                lo_next    = ram_rdata;
                state_next = ST_REV_WR_A;
            end
            ST_REV_WR_A:
            begin
                hi_next    = ram_rdata;
                state_next = ST_REV_WR_B;
            end
            ST_REV_WR_B:
            begin
                state_next = ST_REV_NEXT;
            end
            ST_REV_NEXT:
            begin
                if (i_reg == n_len - CW'(1))
                begin
                    s_next     = LW'(1);
                    state_next = ST_STAGE_INIT;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_REV_RD_A;
                end
            end
            // stage root: root^(n/size)
            ST_STAGE_INIT:
            begin
                phase_next = PH_STEP;
                pb_next    = root_reg;
                pa_next    = 30'd1;
                pe_next    = 32'(n_len >> s_reg);
                psq_next   = 1'b0;
                state_next = ST_POW_MUL;
            end
            ST_BF_RD_LO:
            begin
                state_next = ST_BF_RD_HI;
            end
            ST_BF_RD_HI:
            begin
                lo_next    = ram_rdata;
                state_next = ST_BF_MUL_GO;
            end
            ST_BF_MUL_GO:
            begin
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                if (mul_rsp.done)
                begin
                    hi_next    = mul_rsp.product;
                    state_next = ST_BF_WR_HI;
                end
            end
            ST_BF_WR_HI:
            begin
                state_next = ST_BF_WR_LO;
            end
            ST_BF_WR_LO:
            begin
                state_next = ST_BF_W;
            end
            ST_BF_W:
            begin
                if (mul_rsp.done)
                begin
                    w_next     = mul_rsp.product;
                    state_next = ST_BF_NEXT;
                end
            end
            ST_BF_NEXT:
            begin
                if (i_reg == half - CW'(1))
                begin
                    i_next = '0;
                    w_next = 30'd1;
                    if (j_reg + (half << 1) >= n_len)
                    begin
                        if (s_reg == lg_reg)
                        begin
                            if (inv_reg)
                            begin
                                phase_next = PH_SCALE;
                                pb_next    = 30'(n_len);
                                pa_next    = 30'd1;
                                pe_next    = 32'(MODULUS) - 32'd2;
                                psq_next   = 1'b0;
                                state_next = ST_POW_MUL;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        else
                        begin
                            s_next     = s_reg + LW'(1);
                            state_next = ST_STAGE_INIT;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + (half << 1);
                        state_next = ST_BF_RD_LO;
                    end
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_BF_RD_LO;
                end
            end
            ST_SC_RD:
            begin
                state_next = ST_SC_MUL_GO;
            end
            ST_SC_MUL_GO:
            begin
                state_next = ST_SC_MUL;
            end
            ST_SC_MUL:
            begin
                if (mul_rsp.done)
                begin
                    lo_next    = mul_rsp.product;
                    state_next = ST_SC_WR;
                end
            end
            ST_SC_WR:
            begin
                if (i_reg == n_len - CW'(1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_SC_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // RAM and multiplier drive
    always_comb
    begin
        ram_we     = 1'b0;
        ram_addr   = cmd_reg.index[LOG_MAX-1:0];
        ram_wdata  = '0;
        mul_req    = '0;
        unique case (state_reg)
            ST_WRITE:
            begin
                ram_we    = CW'(cmd_reg.index) < n_len;
                ram_wdata = val_red;
            end
            ST_REV_RD_A:  ram_addr = i_reg[LOG_MAX-1:0];
            ST_REV_RD_B:  ram_addr = rev_i[LOG_MAX-1:0];
            ST_REV_WR_A:
            begin
                ram_we    = 1'b1;
                ram_addr  = i_reg[LOG_MAX-1:0];
                ram_wdata = ram_rdata;
            end
            ST_REV_WR_B:
            begin
                ram_we    = 1'b1;
                ram_addr  = rev_i[LOG_MAX-1:0];
                ram_wdata = lo_reg;
            end
            ST_POW_MUL:
            begin
                mul_req.start = pe_reg != '0;
                mul_req.a     = psq_reg ? pb_reg : pa_reg;
                mul_req.b     = pb_reg;
            end
            ST_BF_RD_LO:  ram_addr = LOG_MAX'(j_reg + i_reg);
            ST_BF_RD_HI:
            begin
                ram_addr      = LOG_MAX'(j_reg + i_reg + half);
            end
            // hi word is on the read port now
            ST_BF_MUL_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = w_reg;
                mul_req.b     = ram_rdata;
            end
            ST_BF_WR_HI:
            begin
                ram_we        = 1'b1;
                ram_addr      = LOG_MAX'(j_reg + i_reg + half);
                ram_wdata     = sum_hi;
                mul_req.start = 1'b1;
                mul_req.a     = w_reg;
                mul_req.b     = step_reg;
            end
            ST_BF_WR_LO:
            begin
                ram_we    = 1'b1;
                ram_addr  = LOG_MAX'(j_reg + i_reg);
                ram_wdata = sum_lo;
            end
            ST_SC_RD:     ram_addr = i_reg[LOG_MAX-1:0];
            ST_SC_MUL_GO:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = scale_reg;
                mul_req.b     = ram_rdata;
            end
            ST_SC_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = i_reg[LOG_MAX-1:0];
                ram_wdata = lo_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_ROOT;
            out_v_reg <= 1'b0;
            scale_reg <= 30'd1;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            out_v_reg <= (state_reg == ST_READ_OUT) || (state_reg == ST_DONE);
            scale_reg <= scale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        lg_reg       <= lg_next;
        inv_reg      <= inv_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        s_reg        <= s_next;
        root_reg     <= root_next;
        step_reg     <= step_next;
        w_reg        <= w_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        pb_reg       <= pb_next;
        pa_reg       <= pa_next;
        pe_reg       <= pe_next;
        psq_reg      <= psq_next;
        out_d_reg    <= out_d_next;
        rd_valid_reg <= out_v_next;
    end

    assign busy          = state_reg != ST_IDLE;
    assign result_strobe = out_v_reg;
    assign result        = {out_d_reg, rd_valid_reg};

endmodule

/* rtl/core/number_theoretic_transform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_theoretic_transform: radix-2 NTT modulo 998244353
// Top level with configuration registers, coefficient RAM, sequencer and
// shared modular multiplier.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with done high, and the receiver
// cannot stall it. A write or a read shows its result when busy is already
// low again. Every product goes through the one modular multiplier. A
// transform of N = 2^log_size points (log_size clamped to 1..LOG_MAX) first
// computes the root (60 - 2*log2(N) products), runs the bit-reversal, then
// (N/2)*log2(N) butterflies; each stage root costs one exponentiation of up
// to 2*log2(N) products. Inverse mode adds a root inversion (2*log2(N)
// products), a Fermat inversion of N (60 products) and N scaling steps. The
// configuration channel is ready at all times.
// ----------------------------------------------------------------------------
module number_theoretic_transform
    import ntt_pkg::*;
#(
    parameter int LOG_MAX = LOG_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  ntt_in_t     cmd,
    output logic        done,
    output ntt_out_t    result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    logic [3:0]         log_size_reg;
    logic               inverse_reg;
    ntt_mul_req_t       mul_req;
    ntt_mul_rsp_t       mul_rsp;
    logic               ram_we;
    logic [LOG_MAX-1:0] ram_addr;
    logic [29:0]        ram_wdata;
    logic [29:0]        ram_rdata;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_size_reg <= 4'd10;
            inverse_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOG_SIZE: log_size_reg <= cfg_data;
                REG_INVERSE:  inverse_reg  <= cfg_data[0];
                default:      inverse_reg  <= inverse_reg;
            endcase
        end
    end

    ntt_seq #(.LOG_MAX(LOG_MAX)) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .log_size      (log_size_reg),
        .inverse_mode  (inverse_reg),
        .busy          (busy),
        .result_strobe (done),
        .result        (result),
        .mul_req       (mul_req),
        .mul_rsp       (mul_rsp),
        .ram_we        (ram_we),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata),
        .ram_rdata     (ram_rdata)
    );

    ntt_modmul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    ntt_ram #(.WIDTH(30), .DEPTH(1 << LOG_MAX)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule

/* test/number_theoretic_transform_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_theoretic_transform_test: self-checking bench for the NTT block
// Drives write, transform, read and unused-opcode commands over several
// length and direction settings. Results are checked against a behavioral
// coefficient store model held in the bench, or against fixed directed values.
// ----------------------------------------------------------------------------
module number_theoretic_transform_test;
    import ntt_pkg::*;

    localparam int STORE_DEPTH = 1 << LOG_MAX_DEF;
    localparam logic [1:0] KIND_NONE = 2'd3;   // unused opcode, must be a no-op
    localparam int NUM_PHASES = 11;

    typedef struct {
        ntt_in_t  c;
        bit       typed;
        ntt_out_t res;
    } cmd_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ntt_in_t  cmd;
    logic     done;
    ntt_out_t result;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_index;
    logic [3:0] cfg_data;

    // Model state
    logic [29:0] coef_mem [STORE_DEPTH];
    bit          coef_set [STORE_DEPTH];
    logic [3:0]  log_reg;
    bit          inv_reg;

    ntt_out_t result_queue [$];
    int       failures;
    bit       no_gaps;

    number_theoretic_transform u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Modular arithmetic
    function automatic logic [29:0] mulmod(logic [29:0] a, logic [29:0] b);
        longint unsigned p;
        p = 64'(a) * 64'(b);
        return 30'(p % 64'(MODULUS));
    endfunction

    function automatic logic [29:0] powmod(logic [29:0] b, int unsigned e);
        logic [29:0] acc;
        acc = 30'd1;
        while (e != 0)
        begin
            if (e[0])
                acc = mulmod(acc, b);
            b = mulmod(b, b);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic int active_log();
        if (log_reg < 1)
            return 1;
        if (log_reg > LOG_MAX_DEF)
            return LOG_MAX_DEF;
        return int'(log_reg);
    endfunction

    // In-place transform over the first 2^L entries
    function automatic void transform_store();
        int          lg;
        int          n;
        int          r;
        int          x;
        logic [29:0] root;
        logic [29:0] stp;
        logic [29:0] w;
        logic [29:0] lo;
        logic [29:0] t;
        logic [29:0] sc;
        lg = active_log();
        n = 1 << lg;
        root = powmod(GEN, ODD_PART << (TWO_EXP - lg));
        if (inv_reg)
            root = powmod(root, n - 1);
        for (int i = 0; i < n; i++)
        begin
            x = i;
            r = 0;
            for (int k = 0; k < lg; k++)
            begin
                r = (r << 1) | (x & 1);
                x = x >> 1;
            end
            if (i < r)
            begin
                t = coef_mem[i];
                coef_mem[i] = coef_mem[r];
                coef_mem[r] = t;
            end
        end
        for (int sz = 2; sz <= n; sz = sz << 1)
        begin
            stp = powmod(root, n / sz);
            for (int j = 0; j < n; j += sz)
            begin
                w = 30'd1;
                for (int i = 0; i < sz / 2; i++)
                begin
                    lo = coef_mem[j + i];
                    t = mulmod(w, coef_mem[j + i + sz / 2]);
                    coef_mem[j + i + sz / 2] = 30'((64'(lo) + 64'(MODULUS) - 64'(t))
                                                   % 64'(MODULUS));
                    coef_mem[j + i] = 30'((64'(lo) + 64'(t)) % 64'(MODULUS));
                    w = mulmod(w, stp);
                end
            end
        end
        if (inv_reg)
        begin
            sc = powmod(30'(n), int'(MODULUS) - 2);
            for (int i = 0; i < n; i++)
                coef_mem[i] = mulmod(coef_mem[i], sc);
        end
    endfunction

    // Apply one command to the model and return its result
    function automatic ntt_out_t predict_result(ntt_in_t c);
        ntt_out_t o;
        int       n;
        n = 1 << active_log();
        o = '0;
        case (c.kind)
            KIND_WRITE:
                if (int'(c.index) < n)
                begin
                    coef_mem[c.index] = 30'(64'(c.value) % 64'(MODULUS));
                    coef_set[c.index] = 1'b1;
                end
            KIND_TRANSFORM:
                transform_store();
            KIND_READ:
                if (int'(c.index) < n)
                begin
                    o.read_value = coef_mem[c.index];
                    o.read_valid = 1'b1;
                end
            default:
                ;
        endcase
        return o;
    endfunction

    // Issue one command and wait until busy drops
    task automatic send_cmd(ntt_in_t c, bit typed = 1'b0, ntt_out_t res = '0);
        ntt_out_t o;
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        o = predict_result(c);
        result_queue.push_back(typed ? res : o);
    endtask

    task automatic idle_gap();
        int r;
        int k;
        r = $urandom_range(0, 9);
        if (no_gaps || r < 6)
            k = 0;
        else if (r < 9)
            k = $urandom_range(1, 3);
        else
            k = $urandom_range(10, 40);
        if (k > 0)
        begin
            start <= 1'b0;
            repeat (k) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (result_queue.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_reg(logic [0:0] idx, logic [3:0] data);
        drain();
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_LOG_SIZE)
            log_reg = data;
        else
            inv_reg = data[0];
    endtask

    function automatic ntt_in_t make_cmd(logic [1:0] k, logic [9:0] i, logic [29:0] v);
        ntt_in_t c;
        c.kind  = k;
        c.index = i;
        c.value = v;
        return c;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        ntt_out_t want;
        if (rst_n && done)
        begin
            if (result_queue.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d valid=%0b",
                         $time, result.read_value, result.read_valid);
                failures++;
            end
            else
            begin
                want = result_queue.pop_front();
                if (result.read_value !== want.read_value)
                begin
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.read_value, result.read_value);
                    failures++;
                end
                if (result.read_valid !== want.read_valid)
                begin
                    $display("%0t: read_valid expected %0b actual %0b",
                             $time, want.read_valid, result.read_valid);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        cmd_row_t    rows [$];
        int          phase_log [NUM_PHASES];
        bit          phase_inv [NUM_PHASES];
        int          n;
        int          r;
        logic [9:0]  idx;
        logic [29:0] val;
        logic [1:0]  k;

        phase_log = '{10, 1, 0, 4, 2, 3, 15, 5, 6, 1, 3};
        phase_inv = '{0, 1, 0, 1, 0, 1, 1, 0, 1, 0, 1};

        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        failures  = 0;
        no_gaps   = 1'b0;
        log_reg   = 4'd10;
        inv_reg   = 1'b0;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            coef_mem[i] = '0;
            coef_set[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset length, field extremes, reduction, unknown opcode
        rows = '{
            '{make_cmd(KIND_WRITE, 10'd0, 30'd0),                1, '{30'd0, 1'b0}},
            '{make_cmd(KIND_WRITE, 10'd1023, MODULUS - 30'd1),   1, '{30'd0, 1'b0}},
            '{make_cmd(KIND_WRITE, 10'd5, 30'h3FFF_FFFF),        1, '{30'd0, 1'b0}},
            '{make_cmd(KIND_WRITE, 10'd512, MODULUS),            1, '{30'd0, 1'b0}},
            '{make_cmd(KIND_WRITE, 10'h2AA, 30'h1555_5555),      0, '{30'd0, 1'b0}},
            '{make_cmd(KIND_READ, 10'd0, 30'h3FFF_FFFF),         1, '{30'd0, 1'b1}},
            '{make_cmd(KIND_READ, 10'd1023, 30'd0),              1, '{MODULUS - 30'd1, 1'b1}},
            '{make_cmd(KIND_READ, 10'd5, 30'd0),                 1, '{30'd75497470, 1'b1}},
            '{make_cmd(KIND_READ, 10'd512, 30'd0),               1, '{30'd0, 1'b1}},
            '{make_cmd(KIND_READ, 10'h2AA, 30'd0),               0, '{30'd0, 1'b0}},
            '{make_cmd(KIND_NONE, 10'd7, 30'h3FFF_FFFF),         1, '{30'd0, 1'b0}},
            '{make_cmd(KIND_READ, 10'd0, 30'd0),                 1, '{30'd0, 1'b1}}
        };
        foreach (rows[i])
        begin
            send_cmd(rows[i].c, rows[i].typed, rows[i].res);
            idle_gap();
        end

        // Phases over length and direction settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_LOG_SIZE, 4'(phase_log[p]));
            write_reg(REG_INVERSE, 4'(phase_inv[p]));
            n = 1 << active_log();
            no_gaps = (p % 3 == 2);

            // Fill every entry a transform will touch
            if (n <= 64)
                for (int i = 0; i < n; i++)
                    if (!coef_set[i])
                    begin
                        send_cmd(make_cmd(KIND_WRITE, 10'(i), 30'($urandom())));
                        idle_gap();
                    end

            for (int it = 0; it < 70; it++)
            begin
                r = $urandom_range(0, 99);
                idx = 10'($urandom());
                val = 30'($urandom());
                if (r < 3 && n <= 64 && (n < 64 || it == 40))
                    k = KIND_TRANSFORM;
                else if (r < 40)
                    k = KIND_WRITE;
                else if (r < 92)
                    k = KIND_READ;
                else
                    k = KIND_NONE;
                // Most reads land inside the length
                if (k == KIND_READ && $urandom_range(0, 3) != 0)
                    idx = 10'($urandom_range(0, n - 1));
                if (k == KIND_READ && int'(idx) < n && !coef_set[idx])
                    k = KIND_WRITE;
                send_cmd(make_cmd(k, idx, val));
                idle_gap();
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (failures == 0 && result_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
